[hw/rtl/pld_pkg.sv]
// shared types and constants for the posting list decoder
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

  localparam int unsigned IdWidth    = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CtxWidth   = 3;
  localparam int unsigned PosWidth   = 13;
  localparam int unsigned LeftWidth  = 9;

  localparam logic [CtxWidth-1:0] SkipContext = 3'd5;

  typedef enum logic [1:0] {
    PH_DOCID = 2'd0,
    PH_FREQ  = 2'd1,
    PH_HITS  = 2'd2,
    PH_DROP  = 2'd3
  } pld_phase_t;

  typedef enum logic [1:0] {
    ST_POSTING   = 2'd0,
    ST_ZERO_FREQ = 2'd1,
    ST_TRUNCATED = 2'd2
  } pld_status_t;

  typedef struct packed {
    logic [ByteWidth-1:0] list_byte;
    logic                 last_byte;
  } pld_beat_t;

  typedef struct packed {
    logic [IdWidth-1:0]   docid;
    logic [ByteWidth-1:0] freq;
    logic [CtxWidth-1:0]  hit_context;
    logic [PosWidth-1:0]  hit_pos;
    pld_status_t          status;
  } pld_result_t;

endpackage

`default_nettype wire

[hw/rtl/pld_if.sv]
// stream interfaces for list bytes and decoded postings
`timescale 1ns / 1ps
`default_nettype none

interface pld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] list_byte;
  logic       last_byte;

  modport source (output valid, output list_byte, output last_byte, input ready);
  modport sink (input valid, input list_byte, input last_byte, output ready);
endinterface

interface pld_post_if;
  logic        valid;
  logic        ready;
  logic [31:0] docid;
  logic [7:0]  freq;
  logic [2:0]  hit_context;
  logic [12:0] hit_pos;
  logic [1:0]  status;

  modport source (output valid, output docid, output freq, output hit_context,
                  output hit_pos, output status, input ready);
  modport sink (input valid, input docid, input freq, input hit_context,
                input hit_pos, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/pld_parser.sv]
// posting list parser state and single-byte step logic
`timescale 1ns / 1ps
`default_nettype none

module pld_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire pld_pkg::pld_beat_t beat,
  input  wire logic [31:0]        min_docid,
  output logic                    res_valid,
  output pld_pkg::pld_result_t    res
);
  import pld_pkg::*;

  pld_phase_t           phase, phase_next;
  logic [IdWidth-1:0]   id_acc, id_acc_next;
  logic [ByteWidth-1:0] hit_total, hit_total_next;
  logic [LeftWidth-1:0] hit_left, hit_left_next;
  logic [ByteWidth-1:0] high_hold, high_hold_next;
  logic [15:0]          chosen, chosen_next;
  logic                 found, found_next;

  logic [IdWidth-1:0]   id_shift;
  logic [LeftWidth-1:0] left_dec;
  logic [ByteWidth-1:0] b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DOCID;
      id_acc    <= '0;
      hit_total <= '0;
      hit_left  <= '0;
      high_hold <= '0;
      chosen    <= '0;
      found     <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      id_acc    <= id_acc_next;
      hit_total <= hit_total_next;
      hit_left  <= hit_left_next;
      high_hold <= high_hold_next;
      chosen    <= chosen_next;
      found     <= found_next;
    end
  end

  always_comb begin
    b              = beat.list_byte;
    id_shift       = {id_acc[IdWidth-8:0], b[6:0]};
    left_dec       = hit_left - LeftWidth'(1);
    phase_next     = phase;
    id_acc_next    = id_acc;
    hit_total_next = hit_total;
    hit_left_next  = hit_left;
    high_hold_next = high_hold;
    chosen_next    = chosen;
    found_next     = found;
    res_valid      = 1'b0;
    res            = '{docid: id_acc, freq: '0, hit_context: '0, hit_pos: '0,
                       status: ST_TRUNCATED};
    case (phase)
      PH_DOCID: begin
        id_acc_next = id_shift;
        if (!b[7]) begin
          phase_next = PH_FREQ;
        end
        if (beat.last_byte) begin
          res_valid = 1'b1;
          res.docid = id_shift;
        end
      end
      PH_FREQ: begin
        if (b == '0) begin
          res_valid  = 1'b1;
          res.status = ST_ZERO_FREQ;
          phase_next = PH_DROP;
        end else begin
          hit_total_next = b;
          hit_left_next  = {b, 1'b0};
          found_next     = 1'b0;
          chosen_next    = '0;
          phase_next     = PH_HITS;
          res_valid      = beat.last_byte;
        end
      end
      PH_HITS: begin
        if (!hit_left[0]) begin
          high_hold_next = b;
        end else if (!found) begin
          chosen_next = {high_hold, b};
          found_next  = (high_hold[7:5] != SkipContext);
        end
        hit_left_next = left_dec;
        if (left_dec == '0) begin
          if (id_acc >= min_docid) begin
            res_valid       = 1'b1;
            res.freq        = hit_total;
            res.hit_context = chosen_next[15:13];
            res.hit_pos     = chosen_next[12:0];
            res.status      = ST_POSTING;
          end
          phase_next     = PH_DOCID;
          id_acc_next    = '0;
          hit_total_next = '0;
          hit_left_next  = '0;
          high_hold_next = '0;
          chosen_next    = '0;
          found_next     = 1'b0;
        end else begin
          res_valid = beat.last_byte;
        end
      end
      PH_DROP: begin
        res_valid = 1'b0;
      end
      default: begin
        phase_next = PH_DOCID;
      end
    endcase
    // end of list returns to the start state
    if (beat.last_byte) begin
      phase_next     = PH_DOCID;
      id_acc_next    = '0;
      hit_total_next = '0;
      hit_left_next  = '0;
      high_hold_next = '0;
      chosen_next    = '0;
      found_next     = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/posting_list_decoder.sv]
// posting_list_decoder: variable-byte posting list decoder, top level
//
// list_in takes one list byte per beat, last_byte marks the final byte of a
// list. post_out gives one beat per emitted posting or error: docid, freq,
// the chosen hit (first hit whose context is not 5, else the last hit) and
// status (0 posting, 1 zero frequency, 2 truncated list).
// cfg_we / cfg_data write min_docid; postings below it are consumed silently.
// Write it only while no list bytes are in flight.
// A byte accepted from list_in is held in the input register; the parser step on
// it loads its result into the result register, which drives post_out.
// Throughput: one byte per cycle while post_out is not stalled.
// If post_out stalls, one result waits in the result register and one byte in
// the input register; list_in.ready drops after that.
// Reset clears the parser to the start of a list, empties both registers and
// sets min_docid to 0.
`timescale 1ns / 1ps
`default_nettype none

module posting_list_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  pld_byte_if.sink         list_in,
  pld_post_if.source       post_out,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  import pld_pkg::*;

  logic [31:0] min_docid_reg;
  logic        s1_valid;
  pld_beat_t   s1_beat;
  logic        s1_go;
  logic        res_valid;
  pld_result_t res;
  logic        out_valid;
  pld_result_t out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_docid_reg <= '0;
    end else if (cfg_we) begin
      min_docid_reg <= cfg_data;
    end
  end

  assign s1_go         = s1_valid && (!out_valid || post_out.ready);
  assign list_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (list_in.ready) begin
      s1_valid <= list_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (list_in.ready && list_in.valid) begin
      s1_beat <= '{list_byte: list_in.list_byte, last_byte: list_in.last_byte};
    end
  end

  pld_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .beat      (s1_beat),
    .min_docid (min_docid_reg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (post_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_reg <= res;
    end
  end

  assign post_out.valid       = out_valid;
  assign post_out.docid       = out_reg.docid;
  assign post_out.freq        = out_reg.freq;
  assign post_out.hit_context = out_reg.hit_context;
  assign post_out.hit_pos     = out_reg.hit_pos;
  assign post_out.status      = out_reg.status;

endmodule

`default_nettype wire

[hw/rtl/pld_checker.sv]
// port-level checks for the posting list decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] docid,
  input wire logic [7:0]  freq,
  input wire logic [2:0]  hit_context,
  input wire logic [12:0] hit_pos,
  input wire logic [1:0]  status
);
  import pld_pkg::*;

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(docid) && $stable(status))
    else $error("result beat changed while stalled");

  // no beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat valid right after reset");

  // error beats carry no hit
  a_error_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ZERO_FREQ || status == ST_TRUNCATED)
      |-> freq == 8'd0 && hit_context == 3'd0 && hit_pos == 13'd0)
    else $error("error beat carries hit data");

  // a posting always has hits and a known status
  a_posting_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3 && (status != ST_POSTING || freq != 8'd0))
    else $error("bad status or empty posting");

endmodule

bind posting_list_decoder pld_checker u_pld_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (post_out.valid),
  .out_ready   (post_out.ready),
  .docid       (post_out.docid),
  .freq        (post_out.freq),
  .hit_context (post_out.hit_context),
  .hit_pos     (post_out.hit_pos),
  .status      (post_out.status)
);

`default_nettype wire

[test/tb_top.sv]
// testbench for the posting list decoder: random and directed lists checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import pld_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int ResetCycles   = 7;
  localparam int DrainCycles   = 4;
  localparam int TailCycles    = 10;
  localparam int WatchdogLimit = 1000;
  localparam int HoldAt        = 150;
  localparam int HoldCycles    = 80;
  localparam int QuietFrom     = 700;
  localparam int QuietTo       = 1100;
  localparam int MaxReports    = 10;
  localparam int PhaseBytes    = 320;

  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_CFG,
    STIM_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t           kind;
    logic [ByteWidth-1:0] data;
    logic                 last;
    logic [IdWidth-1:0]   value;
  } stim_t;

  typedef logic [ByteWidth-1:0] byte_q_t[$];

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               cfg_we   = 1'b0;
  logic [IdWidth-1:0] cfg_data = '0;

  pld_byte_if list_bus ();
  pld_post_if post_bus ();

  posting_list_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .list_in  (list_bus),
    .post_out (post_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  stim_t       stim_q[$];
  pld_result_t posting_q[$];

  int unsigned bytes_in     = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  int unsigned drain_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          byte_taken   = 1'b0;
  bit          post_taken   = 1'b0;

  wire quiet_stretch = (bytes_in >= QuietFrom) && (bytes_in < QuietTo);

  // decoder state as the predictor sees it
  pld_phase_t           ph            = PH_DOCID;
  logic [IdWidth-1:0]   id_acc        = '0;
  logic [ByteWidth-1:0] hits_total    = '0;
  logic [LeftWidth-1:0] hit_bytes_rem = '0;
  logic [ByteWidth-1:0] hit_hi        = '0;
  logic [15:0]          pick_hit      = '0;
  logic                 pick_found    = 1'b0;
  logic [IdWidth-1:0]   min_id        = '0;

  function automatic void restart_posting();
    ph            = PH_DOCID;
    id_acc        = '0;
    hits_total    = '0;
    hit_bytes_rem = '0;
    hit_hi        = '0;
    pick_hit      = '0;
    pick_found    = 1'b0;
  endfunction

  function automatic bit decode_list_byte(input logic [ByteWidth-1:0] b, input logic last,
                                          output pld_result_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    case (ph)
      PH_DOCID: begin
        id_acc = {id_acc[IdWidth-8:0], b[6:0]};
        if (!b[7]) ph = PH_FREQ;
        if (last) begin
          emit       = 1'b1;
          res.docid  = id_acc;
          res.status = ST_TRUNCATED;
        end
      end
      PH_FREQ: begin
        if (b == '0) begin
          emit       = 1'b1;
          res.docid  = id_acc;
          res.status = ST_ZERO_FREQ;
          ph         = PH_DROP;
        end else begin
          hits_total    = b;
          hit_bytes_rem = {b, 1'b0};
          pick_found    = 1'b0;
          pick_hit      = '0;
          ph            = PH_HITS;
          if (last) begin
            emit       = 1'b1;
            res.docid  = id_acc;
            res.status = ST_TRUNCATED;
          end
        end
      end
      PH_HITS: begin
        if (!hit_bytes_rem[0]) begin
          hit_hi = b;
        end else if (!pick_found) begin
          pick_hit = {hit_hi, b};
          if (hit_hi[7:5] != SkipContext) pick_found = 1'b1;
        end
        hit_bytes_rem = hit_bytes_rem - 1'b1;
        if (hit_bytes_rem == '0) begin
          if (id_acc >= min_id) begin
            emit            = 1'b1;
            res.docid       = id_acc;
            res.freq        = hits_total;
            res.hit_context = pick_hit[15:13];
            res.hit_pos     = pick_hit[12:0];
            res.status      = ST_POSTING;
          end
          restart_posting();
        end else if (last) begin
          emit       = 1'b1;
          res.docid  = id_acc;
          res.status = ST_TRUNCATED;
        end
      end
      default: ;
    endcase
    if (last) restart_posting();
    return emit;
  endfunction

  function automatic void push_list(input byte_q_t bytes);
    stim_t s;
    foreach (bytes[k]) begin
      s.kind  = STIM_BYTE;
      s.data  = bytes[k];
      s.last  = (k == bytes.size() - 1);
      s.value = '0;
      stim_q.insert(stim_q.size(), s);
    end
  endfunction

  function automatic void push_cmd(input stim_kind_t kind, input logic [IdWidth-1:0] value);
    stim_t s;
    s.kind  = kind;
    s.data  = '0;
    s.last  = 1'b0;
    s.value = value;
    stim_q.insert(stim_q.size(), s);
  endfunction

  // mostly well formed lists, some cut short, some pure noise
  function automatic void add_random_list();
    byte_q_t           q;
    int unsigned       roll;
    int unsigned       n_post;
    int unsigned       id_len;
    int unsigned       freq_roll;
    int unsigned       freq;
    logic [CtxWidth-1:0] ctx;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 8)) q.insert(q.size(), 8'($urandom));
    end else begin
      n_post = $urandom_range(1, 3);
      for (int p = 0; p < n_post; p++) begin
        if ($urandom_range(15) == 0) begin
          repeat (4) q.insert(q.size(), 8'hff);
          q.insert(q.size(), 8'h7f);
        end else begin
          id_len = $urandom_range(1, 5);
          repeat (id_len - 1) q.insert(q.size(), 8'h80 | 8'($urandom_range(127)));
          q.insert(q.size(), 8'($urandom_range(127)));
        end
        freq_roll = $urandom_range(199);
        if (freq_roll == 0) freq = 255;
        else if (freq_roll < 8) freq = 0;
        else freq = $urandom_range(1, 4);
        q.insert(q.size(), 8'(freq));
        if (freq == 0) begin
          repeat ($urandom_range(3)) q.insert(q.size(), 8'($urandom));
          break;
        end
        repeat (freq) begin
          ctx = $urandom_range(1) ? SkipContext : 3'($urandom_range(7));
          q.insert(q.size(), {ctx, 5'($urandom)});
          q.insert(q.size(), 8'($urandom));
        end
      end
      if (roll < 16 && q.size() > 1) q = q[0:$urandom_range(q.size() - 2)];
    end
    push_list(q);
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%s", msg);
  endfunction

  always @(negedge clk) begin : driver
    logic                 nv;
    logic [ByteWidth-1:0] nb;
    logic                 nl;
    logic                 nwe;
    logic [IdWidth-1:0]   nd;
    nv  = list_bus.valid;
    nb  = list_bus.list_byte;
    nl  = list_bus.last_byte;
    nwe = 1'b0;
    nd  = cfg_data;
    if (byte_taken) begin
      void'(stim_q.pop_front());
      nv = 1'b0;
    end
    if (rst) begin
      nv = 1'b0;
    end else if (!nv) begin
      if (drain_left > 0) begin
        drain_left--;
      end else if (stim_q.size() > 0) begin
        case (stim_q[0].kind)
          STIM_BYTE: begin
            if (quiet_stretch || $urandom_range(99) >= 10) begin
              nv = 1'b1;
              nb = stim_q[0].data;
              nl = stim_q[0].last;
            end
          end
          STIM_CFG: begin
            nwe = 1'b1;
            nd  = stim_q[0].value;
            void'(stim_q.pop_front());
          end
          default: begin
            if (posting_q.size() == 0) begin
              drain_left = DrainCycles;
              void'(stim_q.pop_front());
            end
          end
        endcase
      end
    end
    list_bus.valid     <= nv;
    list_bus.list_byte <= nb;
    list_bus.last_byte <= nl;
    cfg_we             <= nwe;
    cfg_data           <= nd;
  end

  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      hold_left--;
      post_bus.ready <= 1'b0;
    end else if (!hold_done && bytes_in >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      post_bus.ready <= 1'b0;
    end else begin
      post_bus.ready <= quiet_stretch || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin : monitor
    pld_result_t got;
    pld_result_t want;
    pld_result_t fresh;
    byte_taken = !rst && list_bus.valid && list_bus.ready;
    post_taken = !rst && post_bus.valid && post_bus.ready;
    if (post_taken) begin
      got.docid       = post_bus.docid;
      got.freq        = post_bus.freq;
      got.hit_context = post_bus.hit_context;
      got.hit_pos     = post_bus.hit_pos;
      got.status      = pld_status_t'(post_bus.status);
      if (posting_q.size() == 0) begin
        note_failure($sformatf("unexpected beat: docid %h freq %h ctx %h pos %h status %0d",
                               got.docid, got.freq, got.hit_context, got.hit_pos, got.status));
      end else begin
        want = posting_q.pop_front();
        if (got.docid !== want.docid || got.freq !== want.freq ||
            got.hit_context !== want.hit_context || got.hit_pos !== want.hit_pos ||
            got.status !== want.status) begin
          note_failure($sformatf({"mismatch: expected docid %h freq %h ctx %h pos %h status %0d,",
                                  " got docid %h freq %h ctx %h pos %h status %0d"},
                                 want.docid, want.freq, want.hit_context, want.hit_pos,
                                 want.status, got.docid, got.freq, got.hit_context,
                                 got.hit_pos, got.status));
        end
      end
    end
    if (byte_taken) begin
      bytes_in++;
      if (decode_list_byte(list_bus.list_byte, list_bus.last_byte, fresh))
        posting_q.insert(posting_q.size(), fresh);
    end
    if (!rst && cfg_we) min_id = cfg_data;
    if (byte_taken || post_taken || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [IdWidth-1:0] min_vals[6];
    int unsigned        phase_start;
    list_bus.valid     = 1'b0;
    list_bus.list_byte = '0;
    list_bus.last_byte = 1'b0;
    post_bus.ready     = 1'b0;
    min_vals = '{32'h0000_0000, 32'h0000_0400, 32'h0020_0000, $urandom, 32'hffff_ffff,
                 32'h0000_0000};

    push_cmd(STIM_CFG, '0);
    // every hit has context 5, so the last one is chosen
    push_list('{8'h00, 8'h01, 8'hbf, 8'hff});
    // five byte id that wraps to all ones, second hit chosen
    push_list('{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h02, 8'ha0, 8'h00, 8'h1f, 8'hff});
    // zero frequency, then dropped bytes
    push_list('{8'h05, 8'h00, 8'h33, 8'h44});
    // zero frequency on the final byte
    push_list('{8'h06, 8'h00});
    // list ends inside the id
    push_list('{8'h81});
    // list ends right after the id
    push_list('{8'h07});
    // list ends on the frequency byte
    push_list('{8'h08, 8'h03});
    // list ends before the final hit byte
    push_list('{8'h09, 8'h01, 8'he0});

    foreach (min_vals[i]) begin
      push_cmd(STIM_DRAIN, '0);
      push_cmd(STIM_CFG, min_vals[i]);
      phase_start = stim_q.size();
      while (stim_q.size() - phase_start < PhaseBytes) add_random_list();
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() > 0 || list_bus.valid) @(posedge clk);
    while (posting_q.size() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0 && posting_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
